/* design/soc_pkg.sv */
// ----------------------------------------------------------------------------
// soc_pkg
// Shared codes and widths for the obstacle collision checker.
// ----------------------------------------------------------------------------
package soc_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] KIND_EMPTY    = 2'd0;
  localparam logic [1:0] KIND_SPHERE   = 2'd1;
  localparam logic [1:0] KIND_CYLINDER = 2'd2;
  localparam logic [1:0] KIND_BOX      = 2'd3;

  localparam logic        REG_RADIUS   = 1'b0;   // register index, from paddr[2]
  localparam logic [15:0] RADIUS_RESET = 16'd38;

  // squarer operand (signed), square result, positions, sqrt width
  localparam int OW  = 19;
  localparam int SQW = 37;
  localparam int PW  = 20;
  localparam int VW  = 36;
  localparam int SW  = 18;

endpackage

/* design/soc_isqrt.sv */
// ----------------------------------------------------------------------------
// soc_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module soc_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [soc_pkg::VW-1:0]     value_i,
  output logic                       done_o,
  output logic [soc_pkg::SW-1:0]     root_o
);

  logic                   busy_q;
  logic [soc_pkg::VW-1:0] v_q, res_q, bit_q;
  logic [soc_pkg::VW-1:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = busy_q && (bit_q == '0);
  assign root_o = res_q[soc_pkg::SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= soc_pkg::VW'(1) << (soc_pkg::VW - 2);
    end else if (busy_q && bit_q != '0) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

/* design/sphere_obstacle_collision_check_core.sv */
// ----------------------------------------------------------------------------
// sphere_obstacle_collision_check_core
// Obstacle table with a sphere/cylinder touch test for a projectile sphere.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    cmd, slot, obstacle_*, probe_*
//   out      output     out_valid_o / out_stall_i  hit
//   cfg      input      APB psel/penable/pready    projectile_radius at 0x0
//
// A write request goes from idle through ST_DONE. A query squares the radius,
// then walks every slot with one shared squarer: empty/box slots are skipped,
// spheres get a distance test, cylinders a side/cap test and, on a miss, a rim
// test that waits on the bit-serial square root; the walk stops at the first
// hit. Reset empties every slot at once. in_stall_o is high while a request is
// in work; the result register lets a finished result wait on out_stall_i.
// ----------------------------------------------------------------------------
module sphere_obstacle_collision_check_core #(
  parameter int MAX_OBSTACLES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [3:0]         slot_i,
  input  logic [1:0]         obstacle_kind_i,
  input  logic               lying_flag_i,
  input  logic signed [15:0] obstacle_x_i,
  input  logic signed [15:0] obstacle_y_i,
  input  logic signed [15:0] obstacle_z_i,
  input  logic [15:0]        obstacle_diameter_i,
  input  logic [15:0]        obstacle_length_i,
  input  logic signed [15:0] probe_x_i,
  input  logic signed [15:0] probe_y_i,
  input  logic signed [15:0] probe_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int OW  = soc_pkg::OW;
  localparam int SQW = soc_pkg::SQW;
  localparam int PW  = soc_pkg::PW;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RR, ST_LOAD, ST_R0, ST_R1, ST_R2, ST_W, ST_DD, ST_CMP,
    ST_SQRT, ST_E0, ST_E1, ST_E1C, ST_E2, ST_E2C, ST_NEXT, ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0] radius_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == soc_pkg::REG_RADIUS) ? {16'b0, radius_q} : 32'b0;

  // obstacle table
  logic [1:0]         kind_q  [MAX_OBSTACLES];
  logic               lying_q [MAX_OBSTACLES];
  logic signed [15:0] tx_q    [MAX_OBSTACLES];
  logic signed [15:0] ty_q    [MAX_OBSTACLES];
  logic signed [15:0] tz_q    [MAX_OBSTACLES];
  logic [15:0]        tdia_q  [MAX_OBSTACLES];
  logic [15:0]        tlen_q  [MAX_OBSTACLES];

  logic             in_acc, tab_we;
  logic [8:0]       slot_ext;
  logic [IDX_W-1:0] wr_idx, idx_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_ext   = 9'(slot_i);
  assign wr_idx     = slot_ext[IDX_W-1:0];
  assign tab_we     = in_acc && (cmd_i == soc_pkg::CMD_WRITE)
                      && (slot_ext < 9'(MAX_OBSTACLES));

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      lying_q[wr_idx] <= lying_flag_i;
      tx_q[wr_idx]    <= obstacle_x_i;
      ty_q[wr_idx]    <= obstacle_y_i;
      tz_q[wr_idx]    <= obstacle_z_i;
      tdia_q[wr_idx]  <= obstacle_diameter_i;
      tlen_q[wr_idx]  <= obstacle_length_i;
    end
  end

  // working registers
  logic signed [15:0] px_q, py_q, pz_q, ex_q, ey_q, ez_q;
  logic [15:0]        dia_q, len_q;
  logic [1:0]         ekind_q;
  logic               elying_q, hit_q, out_valid_q, out_hit_q;
  logic [SQW-1:0]     rad_q, wide_q, dd_q, rr_q, ea_q, sum_q;
  logic [soc_pkg::SW-1:0] s_q;

  // half-LSB geometry
  logic signed [OW-1:0]     dx, dy, dz, mop;
  logic signed [2*OW-1:0]   prod;
  logic [SQW-1:0]           sq;
  logic signed [PW-1:0]     v, w, top, front, back, r2p, lenp;
  logic                     is_cyl, side_cap_hit, sqrt_start, sqrt_done;
  logic [soc_pkg::SW-1:0]   sqrt_root;

  assign dx = OW'($signed({px_q, 1'b0})) - OW'($signed({ex_q, 1'b0}));
  assign dy = OW'($signed({py_q, 1'b0})) - OW'($signed({ey_q, 1'b0}));
  assign dz = OW'($signed({pz_q, 1'b0})) - OW'($signed({ez_q, 1'b0}));

  assign v     = PW'($signed({py_q, 1'b0}));
  assign w     = PW'($signed({pz_q, 1'b0}));
  assign lenp  = $signed(PW'(len_q));
  assign r2p   = $signed(PW'({radius_q, 1'b0}));
  assign top   = PW'($signed({ey_q, 1'b0})) + lenp;
  assign front = PW'($signed({ez_q, 1'b0})) + lenp;
  assign back  = PW'($signed({ez_q, 1'b0})) - lenp;

  assign is_cyl = (ekind_q == soc_pkg::KIND_CYLINDER);

  always_comb begin
    if (!elying_q) begin
      side_cap_hit = ((v <= top) && (rad_q <= wide_q))
                  || ((v <= top + r2p) && (rad_q <= dd_q));
    end else begin
      side_cap_hit = ((w <= front) && (w >= back) && (rad_q <= wide_q))
                  || ((w <= front + r2p) && (w >= back - r2p) && (rad_q <= dd_q));
    end
  end

  // shared squarer operand
  always_comb begin
    case (state_q)
      ST_RR:   mop = $signed(OW'({radius_q, 1'b0}));
      ST_R0:   mop = dx;
      ST_R1:   mop = ((ekind_q == soc_pkg::KIND_SPHERE) || elying_q) ? dy : dz;
      ST_R2:   mop = dz;
      ST_W:    mop = $signed(OW'(dia_q)) + $signed(OW'({radius_q, 1'b0}));
      ST_DD:   mop = $signed(OW'(dia_q));
      ST_E0:   mop = $signed(OW'({1'b0, s_q})) - $signed(OW'(dia_q));
      ST_E1:   mop = elying_q ? OW'(w - front) : OW'(v - top);
      ST_E2:   mop = OW'(w - back);
      default: mop = '0;
    endcase
  end

  assign prod = mop * mop;
  assign sq   = prod[SQW-1:0];

  assign sqrt_start = (state_q == ST_CMP) && is_cyl && !side_cap_hit;

  soc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (rad_q[soc_pkg::VW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= soc_pkg::RADIUS_RESET;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      ez_q        <= '0;
      dia_q       <= '0;
      len_q       <= '0;
      ekind_q     <= soc_pkg::KIND_EMPTY;
      elying_q    <= 1'b0;
      rad_q       <= '0;
      wide_q      <= '0;
      dd_q        <= '0;
      rr_q        <= '0;
      ea_q        <= '0;
      sum_q       <= '0;
      s_q         <= '0;
      for (int i = 0; i < MAX_OBSTACLES; i++) begin
        kind_q[i] <= soc_pkg::KIND_EMPTY;
      end
    end else begin
      if (psel && penable && pwrite && paddr[2] == soc_pkg::REG_RADIUS) begin
        radius_q <= pwdata[15:0];
      end
      if (tab_we) begin
        kind_q[wr_idx] <= obstacle_kind_i;
      end
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            hit_q <= 1'b0;
            idx_q <= '0;
            px_q  <= probe_x_i;
            py_q  <= probe_y_i;
            pz_q  <= probe_z_i;
            state_q <= (cmd_i == soc_pkg::CMD_QUERY) ? ST_RR : ST_DONE;
          end
        end
        ST_RR: begin
          rr_q    <= sq;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          ekind_q  <= kind_q[idx_q];
          elying_q <= lying_q[idx_q];
          ex_q     <= tx_q[idx_q];
          ey_q     <= ty_q[idx_q];
          ez_q     <= tz_q[idx_q];
          dia_q    <= tdia_q[idx_q];
          len_q    <= tlen_q[idx_q];
          if (kind_q[idx_q] == soc_pkg::KIND_SPHERE
              || kind_q[idx_q] == soc_pkg::KIND_CYLINDER) begin
            state_q <= ST_R0;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_R0: begin
          rad_q   <= sq;
          state_q <= ST_R1;
        end
        ST_R1: begin
          rad_q   <= rad_q + sq;
          state_q <= (ekind_q == soc_pkg::KIND_SPHERE) ? ST_R2 : ST_W;
        end
        ST_R2: begin
          rad_q   <= rad_q + sq;
          state_q <= ST_W;
        end
        ST_W: begin
          wide_q  <= sq;
          state_q <= ST_DD;
        end
        ST_DD: begin
          dd_q    <= sq;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (!is_cyl) begin
            if (rad_q <= wide_q) begin
              hit_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_NEXT;
            end
          end else if (side_cap_hit) begin
            hit_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            s_q     <= sqrt_root;
            state_q <= ST_E0;
          end
        end
        ST_E0: begin
          ea_q    <= sq;
          state_q <= ST_E1;
        end
        ST_E1: begin
          sum_q   <= sq + ea_q;
          state_q <= ST_E1C;
        end
        ST_E1C: begin
          if (sum_q <= rr_q) begin
            hit_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= elying_q ? ST_E2 : ST_NEXT;
          end
        end
        ST_E2: begin
          sum_q   <= sq + ea_q;
          state_q <= ST_E2C;
        end
        ST_E2C: begin
          if (sum_q <= rr_q) begin
            hit_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (idx_q == IDX_W'(MAX_OBSTACLES - 1)) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= ST_LOAD;
          end
        end
        ST_DONE: begin
          // result register free, or emptied this cycle
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the obstacle collision checker: loads obstacle
// slots, fires projectile queries and compares every hit flag with an
// in-bench prediction of the sphere and cylinder touch tests.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               cmd;
    logic [3:0]         slot;
    logic [1:0]         kind;
    logic               lying;
    logic signed [15:0] ox, oy, oz;
    logic [15:0]        dia, len;
    logic signed [15:0] px, py, pz;
  } req_t;

  // Scoreboard: keeps its own copy of the obstacle table and radius.
  class hit_board;
    logic signed [15:0] cx[16], cy[16], cz[16];
    logic [1:0]         kd[16];
    logic               ly[16];
    logic [15:0]        dm[16], ln[16];
    logic [15:0]        radius;
    bit                 hits_due[$];
    int                 errors;

    function void clear();
      for (int i = 0; i < 16; i++) begin
        cx[i] = 0; cy[i] = 0; cz[i] = 0; kd[i] = soc_pkg::KIND_EMPTY;
        ly[i] = 0; dm[i] = 0; ln[i] = 0;
      end
      radius = soc_pkg::RADIUS_RESET;
      errors = 0;
    endfunction

    function longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function bit rim(longint a, longint s, longint d, longint r2);
      return a * a + (s - d) * (s - d) <= r2 * r2;
    endfunction

    // all in half-LSB units
    function bit touches(int i, longint px2, longint py2, longint pz2, longint r2);
      longint d, l, dx, dy, dz, wide, rad2, s, top, fr, bk;
      d = dm[i]; l = ln[i];
      dx = px2 - 2 * longint'(cx[i]);
      dy = py2 - 2 * longint'(cy[i]);
      dz = pz2 - 2 * longint'(cz[i]);
      wide = (d + r2) * (d + r2);
      if (kd[i] == soc_pkg::KIND_SPHERE) return dx * dx + dy * dy + dz * dz <= wide;
      if (kd[i] != soc_pkg::KIND_CYLINDER) return 0;
      if (!ly[i]) begin
        rad2 = dx * dx + dz * dz;
        s = root_floor(rad2);
        top = 2 * longint'(cy[i]) + l;
        if (py2 <= top && rad2 <= wide) return 1;
        if (py2 <= top + r2 && rad2 <= d * d) return 1;
        return rim(py2 - top, s, d, r2);
      end
      rad2 = dx * dx + dy * dy;
      s = root_floor(rad2);
      fr = 2 * longint'(cz[i]) + l;
      bk = 2 * longint'(cz[i]) - l;
      if (pz2 <= fr && pz2 >= bk && rad2 <= wide) return 1;
      if (pz2 <= fr + r2 && pz2 >= bk - r2 && rad2 <= d * d) return 1;
      if (rim(pz2 - fr, s, d, r2)) return 1;
      return rim(pz2 - bk, s, d, r2);
    endfunction

    function void note_request(req_t q);
      bit h;
      h = 0;
      if (q.cmd == soc_pkg::CMD_WRITE) begin
        cx[q.slot] = q.ox; cy[q.slot] = q.oy; cz[q.slot] = q.oz;
        kd[q.slot] = q.kind; ly[q.slot] = q.lying;
        dm[q.slot] = q.dia; ln[q.slot] = q.len;
      end else begin
        for (int i = 0; i < 16; i++)
          if (touches(i, 2 * longint'(q.px), 2 * longint'(q.py), 2 * longint'(q.pz),
                      2 * longint'(radius)))
            h = 1;
      end
      hits_due = {hits_due, h};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_hit(logic got);
      bit want;
      if (hits_due.size() == 0) begin
        report($sformatf("unexpected result hit=%b", got));
        return;
      end
      want = hits_due.pop_front();
      if (got !== want) begin
        report($sformatf("hit got %b want %b", got, want));
      end
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0, hit_o;
  logic cmd_i = 0, lying_flag_i = 0;
  logic [3:0] slot_i = 0;
  logic [1:0] obstacle_kind_i = 0;
  logic signed [15:0] obstacle_x_i = 0, obstacle_y_i = 0, obstacle_z_i = 0;
  logic [15:0] obstacle_diameter_i = 0, obstacle_length_i = 0;
  logic signed [15:0] probe_x_i = 0, probe_y_i = 0, probe_z_i = 0;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  hit_board board;
  bit stalls_on;

  sphere_obstacle_collision_check_core dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // result side: random stalls, sample at rising edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_hit(hit_o);
      @(negedge clk_i);
      out_stall_i <= stalls_on && ($urandom_range(0, 3) == 0);
    end
  end

  // the block stalls after each accepted request, so the extra
  // falling edge costs no throughput
  task automatic send(req_t q);
    int g;
    g = stalls_on ? gap_len() : 0;
    repeat (g + 1) @(negedge clk_i);
    in_valid_i <= 1; cmd_i <= q.cmd; slot_i <= q.slot; obstacle_kind_i <= q.kind;
    lying_flag_i <= q.lying; obstacle_x_i <= q.ox; obstacle_y_i <= q.oy;
    obstacle_z_i <= q.oz; obstacle_diameter_i <= q.dia; obstacle_length_i <= q.len;
    probe_x_i <= q.px; probe_y_i <= q.py; probe_z_i <= q.pz;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(q);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic set_radius(logic [15:0] r);
    while (board.hits_due.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {16'd0, r};
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.radius = r;
  endtask

  function automatic req_t rand_req();
    req_t q;
    q.cmd = 1'($urandom_range(0, 1));
    q.slot = 4'($urandom); q.kind = 2'($urandom); q.lying = 1'($urandom);
    q.ox = 16'($urandom); q.oy = 16'($urandom); q.oz = 16'($urandom);
    q.dia = 16'($urandom); q.len = 16'($urandom);
    q.px = 16'($urandom); q.py = 16'($urandom); q.pz = 16'($urandom);
    return q;
  endfunction

  // obstacles and probes kept near each other so hits and misses both occur
  function automatic req_t near_req(bit is_query);
    req_t q;
    q = rand_req();
    q.cmd = is_query ? soc_pkg::CMD_QUERY : soc_pkg::CMD_WRITE;
    q.kind = ($urandom_range(0, 5) == 0) ? 2'($urandom) :
             ($urandom_range(0, 1) ? soc_pkg::KIND_SPHERE : soc_pkg::KIND_CYLINDER);
    q.ox = 16'(int'($urandom_range(0, 4000)) - 2000);
    q.oy = 16'(int'($urandom_range(0, 4000)) - 2000);
    q.oz = 16'(int'($urandom_range(0, 4000)) - 2000);
    q.dia = 16'($urandom_range(0, 1500)); q.len = 16'($urandom_range(0, 3000));
    q.px = 16'(int'($urandom_range(0, 5000)) - 2500);
    q.py = 16'(int'($urandom_range(0, 5000)) - 2500);
    q.pz = 16'(int'($urandom_range(0, 5000)) - 2500);
    if ($urandom_range(0, 15) == 0) begin
      q.px = 16'($urandom); q.dia = 16'($urandom);
    end
    return q;
  endfunction

  initial begin
    req_t q;
    logic [15:0] radii[5];
    board = new();
    board.clear();
    stalls_on = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty table, each kind, both orientations, extremes
    q = rand_req(); q.cmd = soc_pkg::CMD_QUERY; q.px = 0; q.py = 0; q.pz = 0; send(q);
    q = rand_req(); q.cmd = soc_pkg::CMD_WRITE; q.slot = 0; q.kind = soc_pkg::KIND_SPHERE;
    q.ox = 100; q.oy = 0; q.oz = 0; q.dia = 100; send(q);
    q.cmd = soc_pkg::CMD_QUERY; q.px = 150; q.py = 0; q.pz = 0; send(q);
    q.px = 300; send(q);
    q = rand_req(); q.cmd = soc_pkg::CMD_WRITE; q.slot = 1;
    q.kind = soc_pkg::KIND_CYLINDER; q.lying = 0;
    q.ox = -500; q.oy = 0; q.oz = 0; q.dia = 200; q.len = 400; send(q);
    q.cmd = soc_pkg::CMD_QUERY; q.px = -500; q.py = -30000; q.pz = 0; send(q);
    q.py = 410; send(q);
    q.px = -380; q.py = 220; send(q);
    q = rand_req(); q.cmd = soc_pkg::CMD_WRITE; q.slot = 2;
    q.kind = soc_pkg::KIND_CYLINDER; q.lying = 1;
    q.ox = 800; q.oy = 800; q.oz = 800; q.dia = 200; q.len = 300; send(q);
    q.cmd = soc_pkg::CMD_QUERY; q.px = 800; q.py = 800; q.pz = 970; send(q);
    q.pz = 620; send(q);
    q.px = 900; q.pz = 960; send(q);
    q = rand_req(); q.cmd = soc_pkg::CMD_WRITE; q.slot = 3; q.kind = soc_pkg::KIND_BOX;
    q.ox = 2000; q.oy = 2000; q.oz = 2000; q.dia = 16'hFFFF; q.len = 16'hFFFF; send(q);
    q.cmd = soc_pkg::CMD_QUERY; q.px = 2000; q.py = 2000; q.pz = 2000; send(q);
    q = rand_req(); q.cmd = soc_pkg::CMD_WRITE; q.slot = 15; q.kind = soc_pkg::KIND_SPHERE;
    q.ox = -32768; q.oy = 32767; q.oz = -32768; q.dia = 16'hFFFF; send(q);
    q.cmd = soc_pkg::CMD_QUERY; q.px = 32767; q.py = -32768; q.pz = 32767; send(q);
    q.px = -32768; q.py = 32767; q.pz = -32768; send(q);
    q = rand_req(); q.cmd = soc_pkg::CMD_WRITE; q.slot = 4; q.kind = soc_pkg::KIND_EMPTY;
    send(q);

    radii[0] = 16'd0; radii[1] = 16'hFFFF; radii[2] = 16'd38;
    radii[3] = 16'd300; radii[4] = 16'd1;
    stalls_on = 1;
    for (int ph = 0; ph < 5; ph++) begin
      set_radius(radii[ph]);
      stalls_on = (ph != 2);
      for (int n = 0; n < 270; n++) begin
        if ($urandom_range(0, 9) == 0) q = rand_req();
        else q = near_req($urandom_range(0, 2) != 0);
        send(q);
      end
    end

    while (board.hits_due.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (board.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
